### sv/mcpm_pkg.sv
// shared types and codes for the pcm mixer
package mcpm_pkg;

  localparam int unsigned DataW  = 8;
  localparam int unsigned AddrW  = 16;
  localparam int unsigned LenW   = 17;
  localparam int unsigned RateW  = 16;
  localparam int unsigned GainW  = 12;
  localparam int unsigned MaskW  = 4;
  localparam int unsigned SmpW   = 16;
  localparam int unsigned ProdW  = 21;

  typedef enum logic [2:0] {
    FN_TICK  = 3'd0,
    FN_LOAD  = 3'd1,
    FN_START = 3'd2,
    FN_STOP  = 3'd3,
    FN_RATE  = 3'd4,
    FN_GAIN  = 3'd5,
    FN_NEXT  = 3'd6
  } func_e;

  typedef enum logic [2:0] {
    CH_NONE,
    CH_START,
    CH_STOP,
    CH_RATE,
    CH_GAIN,
    CH_NEXT,
    CH_ADVANCE
  } chan_op_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [1:0]       chan;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [LenW-1:0]  length;
    logic             repeat_req;
    logic [RateW-1:0] rate_inc;
    logic [GainW-1:0] gain;
  } in_item_t;

  typedef struct packed {
    logic signed [SmpW-1:0] out_sample;
    logic [MaskW-1:0]       active_mask;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic mul;
    logic acc;
  } mac_ctrl_t;

endpackage

### sv/mcpm_mem.sv
// byte-wide sample memory, one port, registered read
module mcpm_mem #(
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic                            re_i,
  input  logic [$clog2(SAMPLE_DEPTH)-1:0] addr_i,
  input  logic [7:0]                      wdata_i,
  output logic [7:0]                      rdata_o
);
  import mcpm_pkg::*;

  logic [DataW-1:0] mem_q [SAMPLE_DEPTH];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/mcpm_chan.sv
// per-channel playback state and its update logic
module mcpm_chan #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned FRAC_BITS = 10,
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mcpm_pkg::chan_op_e    op_i,
  input  logic [CW-1:0]         idx_i,
  input  mcpm_pkg::in_item_t    item_i,
  output logic [15:0]           play_addr_o,
  output logic [11:0]           gain_o,
  output logic                  active_o,
  output logic [CHANNELS-1:0]   mask_o
);
  import mcpm_pkg::*;

  localparam int unsigned AccW = RateW + 1;

  logic [AddrW-1:0]     play_addr_q [CHANNELS];
  logic [LenW-1:0]      remaining_q [CHANNELS];
  logic [FRAC_BITS-1:0] phase_q     [CHANNELS];
  logic [RateW-1:0]     rate_q      [CHANNELS];
  logic [GainW-1:0]     gain_q      [CHANNELS];
  logic [AddrW-1:0]     loop_addr_q [CHANNELS];
  logic [LenW-1:0]      loop_len_q  [CHANNELS];

  logic [AccW-1:0] acc;
  logic [AccW-1:0] adv;
  logic            same_next;

  assign acc = AccW'(rate_q[idx_i]) + AccW'(phase_q[idx_i]);
  assign adv = acc >> FRAC_BITS;

  assign same_next = (remaining_q[idx_i] != '0) &&
                     (loop_addr_q[idx_i] == item_i.addr) &&
                     (loop_len_q[idx_i] == item_i.length);

  assign play_addr_o = play_addr_q[idx_i];
  assign gain_o      = gain_q[idx_i];
  assign active_o    = remaining_q[idx_i] != '0;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mask_o[c] = remaining_q[c] != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        play_addr_q[c] <= '0;
        remaining_q[c] <= '0;
        phase_q[c]     <= '0;
        rate_q[c]      <= '0;
        gain_q[c]      <= '0;
        loop_addr_q[c] <= '0;
        loop_len_q[c]  <= '0;
      end
    end else begin
      unique case (op_i)
        CH_START: begin
          play_addr_q[idx_i] <= item_i.addr;
          remaining_q[idx_i] <= item_i.length;
          phase_q[idx_i]     <= '0;
          rate_q[idx_i]      <= item_i.rate_inc;
          gain_q[idx_i]      <= item_i.gain;
          if (item_i.repeat_req) begin
            loop_addr_q[idx_i] <= item_i.addr;
            loop_len_q[idx_i]  <= item_i.length;
          end else begin
            loop_len_q[idx_i]  <= '0;
          end
        end
        CH_STOP: begin
          remaining_q[idx_i] <= '0;
        end
        CH_RATE: begin
          rate_q[idx_i] <= item_i.rate_inc;
        end
        CH_GAIN: begin
          gain_q[idx_i] <= item_i.gain;
        end
        CH_NEXT: begin
          if (!same_next) begin
            if (remaining_q[idx_i] == '0) begin
              play_addr_q[idx_i] <= item_i.addr;
              remaining_q[idx_i] <= item_i.length;
            end
            loop_addr_q[idx_i] <= item_i.addr;
            loop_len_q[idx_i]  <= item_i.length;
          end
        end
        CH_ADVANCE: begin
          if (remaining_q[idx_i] != '0) begin
            // end of block: continue with the queued one, zero length stops
            if (adv >= AccW'(remaining_q[idx_i])) begin
              remaining_q[idx_i] <= loop_len_q[idx_i];
              play_addr_q[idx_i] <= loop_addr_q[idx_i];
              phase_q[idx_i]     <= '0;
            end else begin
              remaining_q[idx_i] <= remaining_q[idx_i] - LenW'(adv);
              play_addr_q[idx_i] <= play_addr_q[idx_i] + AddrW'(adv);
              phase_q[idx_i]     <= acc[FRAC_BITS-1:0];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### sv/mcpm_mac.sv
// shared multiply-accumulate unit with output clamp
module mcpm_mac #(
  parameter int unsigned CHANNELS  = 4,
  parameter int unsigned FRAC_BITS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mcpm_pkg::mac_ctrl_t  ctrl_i,
  input  logic [7:0]           byte_i,
  input  logic [11:0]          gain_i,
  output logic signed [15:0]   out_sample_o
);
  import mcpm_pkg::*;

  localparam int unsigned BaseW = (FRAC_BITS + 9 > ProdW) ? FRAC_BITS + 9 : ProdW;
  localparam int unsigned SumW  = BaseW + $clog2(CHANNELS + 1) + 1;
  localparam logic signed [SumW-1:0] SumInit = SumW'(128) << FRAC_BITS;

  logic signed [8:0]       centered;
  logic signed [ProdW+1:0] prod_full;
  logic signed [ProdW-1:0] product_q;
  logic signed [SumW-1:0]  sum_q;
  logic signed [SumW-1:0]  shifted;
  logic [7:0]              clamped;

  assign centered  = $signed({1'b0, byte_i}) - 9'sd128;
  assign prod_full = centered * $signed({1'b0, gain_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q     <= '0;
      product_q <= '0;
    end else begin
      if (ctrl_i.clear) begin
        sum_q <= SumInit;
      end else if (ctrl_i.acc) begin
        sum_q <= sum_q + SumW'(product_q);
      end
      if (ctrl_i.mul) begin
        product_q <= ProdW'(prod_full);
      end
    end
  end

  assign shifted = sum_q >>> FRAC_BITS;

  always_comb begin
    priority if (sum_q[SumW-1]) begin
      clamped = '0;
    end else if (|shifted[SumW-2:8]) begin
      clamped = 8'hFF;
    end else begin
      clamped = shifted[7:0];
    end
  end

  // (byte - 128) * 256
  assign out_sample_o = $signed({~clamped[7], clamped[6:0], 8'h00});

endmodule

### sv/multichannel_pcm_mixer.sv
// tick: each active channel passes through the read, multiply and accumulate states and
// each idle channel through the read state only, then the done state loads the output
// register and the next beat is taken back in idle; other items pass through the execute
// state; one item at a time; a result still stalled holds the output load back
// asynchronous active-low reset clears all channel state and the output beat;
// sample memory is not cleared and holds its contents
module multichannel_pcm_mixer #(
  parameter int unsigned CHANNELS     = 4,
  parameter int unsigned FRAC_BITS    = 10,
  parameter int unsigned SAMPLE_DEPTH = 65536
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mcpm_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mcpm_pkg::out_item_t  out_item_o
);
  import mcpm_pkg::*;

  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AW = $clog2(SAMPLE_DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_e;

  state_e     state_q;
  in_item_t   item_q;
  logic [CW-1:0] cnt_q;
  logic       out_valid_q;
  out_item_t  out_item_q;

  logic          accept;
  logic          last;
  logic          chan_ok;
  logic          out_load;
  logic [CW-1:0] cur_idx;
  chan_op_e      chan_op;
  mac_ctrl_t     mac_ctrl;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic [15:0]   play_addr;
  logic [11:0]   cur_gain;
  logic          cur_active;
  logic [CHANNELS-1:0] mask;
  logic [MaskW-1:0]    mask4;
  logic signed [SmpW-1:0] mix_sample;

  assign in_stall_o = state_q != ST_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign last       = cnt_q == CW'(CHANNELS - 1);
  assign chan_ok    = 32'(item_q.chan) < CHANNELS;
  assign cur_idx    = (state_q == ST_EXEC) ? CW'(item_q.chan) : cnt_q;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    chan_op = CH_NONE;
    if (state_q == ST_EXEC && chan_ok) begin
      unique case (item_q.func)
        FN_START: chan_op = CH_START;
        FN_STOP:  chan_op = CH_STOP;
        FN_RATE:  chan_op = CH_RATE;
        FN_GAIN:  chan_op = CH_GAIN;
        FN_NEXT:  chan_op = CH_NEXT;
        default:  chan_op = CH_NONE;
      endcase
    end else if (state_q == ST_RD && cur_active) begin
      chan_op = CH_ADVANCE;
    end
  end

  assign mac_ctrl.clear = accept && (in_item_i.func == FN_TICK);
  assign mac_ctrl.mul   = state_q == ST_MUL;
  assign mac_ctrl.acc   = state_q == ST_ACC;

  assign mem_we   = (state_q == ST_EXEC) && (item_q.func == FN_LOAD);
  assign mem_re   = (state_q == ST_RD) && cur_active;
  assign mem_addr = mem_we ? AW'(item_q.addr) : AW'(play_addr);

  mcpm_mem #(
    .SAMPLE_DEPTH(SAMPLE_DEPTH)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(item_q.data),
    .rdata_o(mem_rdata)
  );

  mcpm_chan #(
    .CHANNELS (CHANNELS),
    .FRAC_BITS(FRAC_BITS)
  ) u_chan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (chan_op),
    .idx_i      (cur_idx),
    .item_i     (item_q),
    .play_addr_o(play_addr),
    .gain_o     (cur_gain),
    .active_o   (cur_active),
    .mask_o     (mask)
  );

  mcpm_mac #(
    .CHANNELS (CHANNELS),
    .FRAC_BITS(FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .byte_i      (mem_rdata),
    .gain_i      (cur_gain),
    .out_sample_o(mix_sample)
  );

  for (genvar b = 0; b < MaskW; b++) begin : g_mask
    if (b < CHANNELS) begin : g_on
      assign mask4[b] = mask[b];
    end else begin : g_off
      assign mask4[b] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      item_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            item_q  <= in_item_i;
            cnt_q   <= '0;
            state_q <= (in_item_i.func == FN_TICK) ? ST_RD : ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
        end
        ST_RD: begin
          // idle channels are skipped without the multiply and accumulate states
          if (cur_active) begin
            state_q <= ST_MUL;
          end else if (last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          state_q <= ST_ACC;
        end
        ST_ACC: begin
          if (last) begin
            state_q <= ST_DONE;
          end else begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= ST_RD;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            out_item_q.out_sample  <= mix_sample;
            out_item_q.active_mask <= mask4;
            state_q                <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

### sv/mcpm_checker.sv
// port-level checks for the pcm mixer, bound to the top level
module mcpm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input mcpm_pkg::in_item_t   in_item_i,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input mcpm_pkg::out_item_t  out_item_o
);
  import mcpm_pkg::*;

  // an accepted beat raises the stall, so two beats are never taken back to back
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken twice in a row");

  // only a tick produces a result
  a_no_result_from_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.func != FN_TICK) |=> !$rose(out_valid_o))
    else $error("result after a non-tick beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_item_o))
    else $error("result changed while stalled");

endmodule

bind multichannel_pcm_mixer mcpm_checker u_mcpm_checker (.*);
